// ===== hw/rtl/kgec_pkg.sv =====
// Shared constants, state encoding and control types of the k-mer group error corrector.
package kgec_pkg;

	localparam int unsigned POS_W   = 32;
	localparam int unsigned CHAR_W  = 2;
	localparam int unsigned LCP_W   = 16;
	localparam int unsigned K_W     = 16;
	localparam int unsigned THR_W   = 5;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_KMER_SIZE        = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRUST_THRESHOLD  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_MIRROR_POS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH     = 8'd3;

	localparam logic [K_W-1:0]   KMER_SIZE_RESET = 16'd31;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 5'd3;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
	localparam logic [CHAR_W-1:0] CHAR_MAX = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRE,
		ST_STORE,
		ST_POST,
		ST_SCAN,
		ST_SEL,
		ST_RD,
		ST_ADD,
		ST_EMIT,
		ST_CLR
	} state_t;

	typedef struct packed {
		logic load;
		logic close_int;
		logic store;
		logic scan;
		logic next_i;
		logic next_j;
		logic emit;
		logic clear_group;
		logic set_empty;
	} cmd_t;

	typedef struct packed {
		logic pre_close;
		logic pre_group;
		logic last_in;
		logic go;
		logic mask_cur;
		logic i_last;
		logic j_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/kgec_ctrl.sv =====
// Controller state machine that sequences item handling and group correction bursts.
module kgec_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  kgec_pkg::sts_t  sts,
	output kgec_pkg::cmd_t  cmd
);

	kgec_pkg::state_t state_q, state_d;
	logic post_q, post_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kgec_pkg::ST_IDLE;
			post_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			post_q  <= post_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		post_d   = post_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			kgec_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = kgec_pkg::ST_PRE;
				end
			end
			kgec_pkg::ST_PRE: begin
				state_d = kgec_pkg::ST_STORE;
				if (sts.pre_close) begin
					cmd.close_int = 1'b1;
					if (sts.pre_group) begin
						post_d  = 1'b0;
						state_d = kgec_pkg::ST_SCAN;
					end
				end
			end
			kgec_pkg::ST_STORE: begin
				cmd.store = 1'b1;
				state_d = sts.last_in ? kgec_pkg::ST_POST : kgec_pkg::ST_IDLE;
			end
			kgec_pkg::ST_POST: begin
				cmd.close_int = 1'b1;
				post_d  = 1'b1;
				state_d = kgec_pkg::ST_SCAN;
			end
			kgec_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = kgec_pkg::ST_SEL;
			end
			kgec_pkg::ST_SEL: begin
				if (!sts.go) begin
					state_d = kgec_pkg::ST_CLR;
				end else if (sts.mask_cur) begin
					state_d = kgec_pkg::ST_RD;
				end else if (sts.i_last) begin
					state_d = kgec_pkg::ST_CLR;
				end else begin
					cmd.next_i = 1'b1;
				end
			end
			kgec_pkg::ST_RD: begin
				state_d = kgec_pkg::ST_ADD;
			end
			kgec_pkg::ST_ADD: begin
				state_d = kgec_pkg::ST_EMIT;
			end
			kgec_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.j_last) begin
						if (sts.i_last) begin
							state_d = kgec_pkg::ST_CLR;
						end else begin
							cmd.next_i = 1'b1;
							state_d = kgec_pkg::ST_SEL;
						end
					end else begin
						cmd.next_j = 1'b1;
						state_d = kgec_pkg::ST_RD;
					end
				end
			end
			kgec_pkg::ST_CLR: begin
				cmd.clear_group = 1'b1;
				if (post_q) begin
					cmd.set_empty = 1'b1;
					state_d = kgec_pkg::ST_IDLE;
				end else begin
					state_d = kgec_pkg::ST_STORE;
				end
			end
			default: begin
				state_d = kgec_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/kgec_dp.sv =====
// Datapath with configuration, interval bookkeeping, position memory and output register.
module kgec_dp #(
	parameter int unsigned ALPHABET  = 4,
	parameter int unsigned MAX_TRUST = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [kgec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kgec_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [kgec_pkg::POS_W-1:0]          in_start,
	input  logic [kgec_pkg::CHAR_W-1:0]         in_char,
	input  logic [kgec_pkg::LCP_W-1:0]          in_lcp,
	input  logic                                in_last,
	input  kgec_pkg::cmd_t                      cmd,
	output kgec_pkg::sts_t                      sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [kgec_pkg::POS_W-1:0]          out_pos,
	output logic [kgec_pkg::CHAR_W-1:0]         out_char,
	output logic                                out_last
);

	localparam int unsigned IW    = $clog2(ALPHABET);
	localparam int unsigned XW    = $clog2(ALPHABET + 1);
	localparam int unsigned JW    = (MAX_TRUST > 1) ? $clog2(MAX_TRUST) : 1;
	localparam int unsigned NW    = $clog2(MAX_TRUST + 1);
	localparam int unsigned DEPTH = ALPHABET * MAX_TRUST;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [kgec_pkg::K_W-1:0]   kmer_size_q;
	logic [kgec_pkg::THR_W-1:0] thr_q;
	logic [kgec_pkg::POS_W-1:0] mirror_q;
	logic [kgec_pkg::POS_W-1:0] total_q;

	logic [kgec_pkg::POS_W-1:0]  start_q;
	logic [kgec_pkg::CHAR_W-1:0] char_q;
	logic [kgec_pkg::LCP_W-1:0]  lcp_q;
	logic                        last_q;

	logic [kgec_pkg::CNT_W-1:0]  cnt_q   [ALPHABET];
	logic [kgec_pkg::CHAR_W-1:0] fchar_q [ALPHABET];
	logic [XW-1:0]               idx_q;
	logic                        all_trusted_q;
	logic                        empty_q;

	logic [kgec_pkg::POS_W-1:0]  mem_q [DEPTH];
	logic [kgec_pkg::POS_W-1:0]  rd_q;
	logic [kgec_pkg::POS_W-1:0]  pos_s1;

	logic [IW-1:0]               i_q;
	logic [JW-1:0]               j_q;
	logic [ALPHABET-1:0]         mask_q;
	logic [IW-1:0]               lasti_q;
	logic                        go_q;
	logic [kgec_pkg::CHAR_W-1:0] trusted_q;

	logic [kgec_pkg::POS_W-1:0]  opos_q;
	logic [kgec_pkg::CHAR_W-1:0] ochar_q;
	logic                        olast_q;
	logic                        ovalid_q;

	logic [kgec_pkg::CNT_W-1:0]  thr_eff;
	logic                        cur_valid;
	logic [kgec_pkg::CNT_W-1:0]  cur_cnt;
	logic [AW-1:0]               waddr;
	logic [AW-1:0]               raddr;
	logic                        wr_en;
	logic [kgec_pkg::CNT_W-1:0]  best;
	logic [IW-1:0]               bestpos;
	logic [ALPHABET-1:0]         mask_d;
	logic [IW-1:0]               lasti_d;
	logic [kgec_pkg::CNT_W-1:0]  sel_cnt;
	logic [NW-1:0]               ncnt_cur;
	logic                        j_last;
	logic [kgec_pkg::POS_W-1:0]  km1;
	logic                        fold;
	logic                        out_free;

	assign thr_eff = (thr_q > kgec_pkg::THR_W'(MAX_TRUST)) ?
		kgec_pkg::CNT_W'(MAX_TRUST) : kgec_pkg::CNT_W'(thr_q);
	assign cur_valid = idx_q < XW'(ALPHABET);
	assign cur_cnt   = cnt_q[idx_q[IW-1:0]];
	assign wr_en     = cmd.store && cur_valid && (cur_cnt < kgec_pkg::CNT_W'(MAX_TRUST));
	assign waddr     = AW'(idx_q[IW-1:0]) * AW'(MAX_TRUST) + AW'(cur_cnt[JW-1:0]);
	assign raddr     = AW'(i_q) * AW'(MAX_TRUST) + AW'(j_q);
	assign km1       = {{(kgec_pkg::POS_W-kgec_pkg::K_W){1'b0}}, kmer_size_q} - 32'd1;
	assign fold      = pos_s1 >= mirror_q;
	assign out_free  = !ovalid_q || out_ready;

	assign sel_cnt  = cnt_q[i_q];
	assign ncnt_cur = (sel_cnt > kgec_pkg::CNT_W'(MAX_TRUST)) ? NW'(MAX_TRUST) : NW'(sel_cnt);
	assign j_last   = (NW'(j_q) + NW'(1)) == ncnt_cur;

	always_comb begin
		best    = '0;
		bestpos = '0;
		mask_d  = '0;
		lasti_d = '0;
		for (int i = 0; i < ALPHABET; i++) begin
			if (cnt_q[i] > best) begin
				best    = cnt_q[i];
				bestpos = IW'(i);
			end
			mask_d[i] = (cnt_q[i] < thr_eff) && (cnt_q[i] != '0);
			if (mask_d[i]) begin
				lasti_d = IW'(i);
			end
		end
	end

	always_comb begin
		sts.pre_close = !empty_q && ({1'b0, lcp_q} < {1'b0, kmer_size_q});
		sts.pre_group = ({1'b0, lcp_q} + 17'd1) < {1'b0, kmer_size_q};
		sts.last_in   = last_q;
		sts.go        = go_q;
		sts.mask_cur  = mask_q[i_q];
		sts.i_last    = i_q == IW'(ALPHABET - 1);
		sts.j_last    = j_last;
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_size_q <= kgec_pkg::KMER_SIZE_RESET;
			thr_q       <= kgec_pkg::THRESHOLD_RESET;
			mirror_q    <= '0;
			total_q     <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				kgec_pkg::REG_KMER_SIZE:        kmer_size_q <= cfg_data[kgec_pkg::K_W-1:0];
				kgec_pkg::REG_TRUST_THRESHOLD:  thr_q <= cfg_data[kgec_pkg::THR_W-1:0];
				kgec_pkg::REG_FIRST_MIRROR_POS: mirror_q <= cfg_data;
				kgec_pkg::REG_TOTAL_LENGTH:     total_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= in_start;
			char_q  <= in_char;
			lcp_q   <= in_lcp;
			last_q  <= in_last;
		end
		if (cmd.store && cur_valid && (cur_cnt == '0)) begin
			fchar_q[idx_q[IW-1:0]] <= char_q;
		end
		if (cmd.scan) begin
			mask_q    <= mask_d;
			lasti_q   <= lasti_d;
			trusted_q <= fchar_q[bestpos];
		end
		pos_s1 <= rd_q + km1;
		if (cmd.emit) begin
			opos_q  <= fold ? (total_q - 32'd1 - pos_s1) : pos_s1;
			ochar_q <= fold ? (kgec_pkg::CHAR_MAX - trusted_q) : trusted_q;
			olast_q <= (i_q == lasti_q) && j_last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= start_q;
		end
		rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET; i++) begin
				cnt_q[i] <= '0;
			end
			idx_q         <= '0;
			all_trusted_q <= 1'b1;
			empty_q       <= 1'b1;
			i_q           <= '0;
			j_q           <= '0;
			go_q          <= 1'b0;
			ovalid_q      <= 1'b0;
		end else begin
			if (cmd.close_int && cur_valid) begin
				if (cur_cnt < thr_eff) begin
					all_trusted_q <= 1'b0;
				end
				idx_q <= idx_q + XW'(1);
			end
			if (cmd.store) begin
				empty_q <= 1'b0;
				if (cur_valid && (cur_cnt != kgec_pkg::CNT_MAX)) begin
					cnt_q[idx_q[IW-1:0]] <= cur_cnt + 16'd1;
				end
			end
			if (cmd.scan) begin
				go_q <= !all_trusted_q && (best >= thr_eff) && (|mask_d);
				i_q  <= '0;
				j_q  <= '0;
			end
			if (cmd.next_i) begin
				i_q <= i_q + IW'(1);
				j_q <= '0;
			end
			if (cmd.next_j) begin
				j_q <= j_q + JW'(1);
			end
			if (cmd.clear_group) begin
				for (int i = 0; i < ALPHABET; i++) begin
					cnt_q[i] <= '0;
				end
				idx_q         <= '0;
				all_trusted_q <= 1'b1;
			end
			if (cmd.set_empty) begin
				empty_q <= 1'b1;
			end
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_pos   = opos_q;
	assign out_char  = ochar_q;
	assign out_last  = olast_q;

endmodule

// ===== hw/rtl/kmer_group_error_corrector_unit.sv =====
// Top level of the k-mer group error corrector: stream ports, controller and datapath.
//
// Takes sorted k-mer occurrences one word at a time and emits base corrections for the
// short intervals of each group. An occurrence that closes no group passes through
// accept, LCP check and position store, and through an interval close before its group
// close when it ends a bucket. A group close goes through scan, select and clear when
// nothing is corrected. Otherwise it goes through the scan, a select for each of the
// ALPHABET interval slots and the clear, and each correction adds a read through the
// single read port of the position memory followed by the address add and the mirror
// fold into the output register. A correction also waits while the previous one is still
// held in the output register. An occurrence whose LCP closes a group and that also ends
// a bucket pays for two group closes. The output register lets the next word be accepted
// while the last correction waits to be taken.
module kmer_group_error_corrector_unit #(
	parameter int unsigned ALPHABET  = 4,
	parameter int unsigned MAX_TRUST = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kgec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kgec_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// kmer_start_pos[31:0], kmer_last_char[33:32], lcp_to_previous[49:34], zeros above.
	input  logic [kgec_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// corrected_pos[31:0], new_char[33:32], zeros above.
	output logic [kgec_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast
);

	kgec_pkg::cmd_t cmd;
	kgec_pkg::sts_t sts;
	logic [kgec_pkg::POS_W-1:0]  out_pos;
	logic [kgec_pkg::CHAR_W-1:0] out_char;

	assign cfg_ready = 1'b1;

	kgec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kgec_dp #(
		.ALPHABET  (ALPHABET),
		.MAX_TRUST (MAX_TRUST)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_start  (s_axis_tdata[31:0]),
		.in_char   (s_axis_tdata[33:32]),
		.in_lcp    (s_axis_tdata[49:34]),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pos   (out_pos),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, out_char, out_pos};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the k-mer group error corrector unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ALPHABET = 4;
	localparam int unsigned MAX_TRUST = 16;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 100_000;
	localparam logic [kgec_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd200;

	typedef enum {LINK_ANY, LINK_SAME, LINK_SIBLING, LINK_NEW_GROUP} link_t;

	typedef struct packed {
		logic [kgec_pkg::POS_W-1:0]  pos;
		logic [kgec_pkg::CHAR_W-1:0] base;
		logic                        tail;
	} fix_t;

	class correction_board;
		logic [kgec_pkg::K_W-1:0]    kmer_size;
		logic [kgec_pkg::THR_W-1:0]  threshold;
		logic [kgec_pkg::POS_W-1:0]  mirror_start;
		logic [kgec_pkg::POS_W-1:0]  total_len;
		logic [kgec_pkg::POS_W-1:0]  positions [ALPHABET][MAX_TRUST];
		logic [kgec_pkg::CHAR_W-1:0] first_base [ALPHABET];
		logic [kgec_pkg::CNT_W-1:0]  counts [ALPHABET];
		int unsigned                 slot;
		bit                          all_trusted;
		bit                          at_bucket_start;
		fix_t                        expected_fixes [$];
		int unsigned                 fails;

		function new();
			kmer_size = kgec_pkg::KMER_SIZE_RESET;
			threshold = kgec_pkg::THRESHOLD_RESET;
			mirror_start = '0;
			total_len = '0;
			foreach (counts[i]) counts[i] = '0;
			slot = 0;
			all_trusted = 1'b1;
			at_bucket_start = 1'b1;
			fails = 0;
		endfunction

		function void set_reg(logic [kgec_pkg::CFG_IDX_W-1:0] index,
				logic [kgec_pkg::CFG_DATA_W-1:0] value);
			case (index)
				kgec_pkg::REG_KMER_SIZE:        kmer_size = value[kgec_pkg::K_W-1:0];
				kgec_pkg::REG_TRUST_THRESHOLD:  threshold = value[kgec_pkg::THR_W-1:0];
				kgec_pkg::REG_FIRST_MIRROR_POS: mirror_start = value;
				kgec_pkg::REG_TOTAL_LENGTH:     total_len = value;
				default: ;
			endcase
		endfunction

		function int unsigned trust_level();
			return (32'(threshold) > MAX_TRUST) ? MAX_TRUST : 32'(threshold);
		endfunction

		function void close_interval();
			if (slot < ALPHABET) begin
				if (32'(counts[slot]) < trust_level())
					all_trusted = 1'b0;
				slot++;
			end
		endfunction

		function void close_group();
			int unsigned                 c_eff;
			int unsigned                 best;
			int unsigned                 best_idx;
			int unsigned                 n_before;
			logic [kgec_pkg::CHAR_W-1:0] trusted;
			logic [kgec_pkg::CHAR_W-1:0] base;
			logic [kgec_pkg::POS_W-1:0]  p;
			fix_t                        fix;
			c_eff = trust_level();
			n_before = expected_fixes.size();
			if (!all_trusted) begin
				best = 0;
				best_idx = 0;
				for (int i = 0; i < ALPHABET; i++) begin
					if (32'(counts[i]) > best) begin
						best = 32'(counts[i]);
						best_idx = i;
					end
				end
				if (best >= c_eff) begin
					trusted = first_base[best_idx];
					for (int i = 0; i < ALPHABET; i++) begin
						if (32'(counts[i]) < c_eff) begin
							for (int j = 0; j < 32'(counts[i]) && j < MAX_TRUST; j++) begin
								p = positions[i][j] + {16'b0, kmer_size} - 32'd1;
								base = trusted;
								if (p >= mirror_start) begin
									p = total_len - 32'd1 - p;
									base = kgec_pkg::CHAR_MAX - base;
								end
								fix.pos = p;
								fix.base = base;
								fix.tail = 1'b0;
								expected_fixes.push_back(fix);
							end
						end
					end
				end
			end
			if (expected_fixes.size() > n_before)
				expected_fixes[expected_fixes.size() - 1].tail = 1'b1;
			all_trusted = 1'b1;
			slot = 0;
			foreach (counts[i]) counts[i] = '0;
		endfunction

		function void note_occurrence(logic [kgec_pkg::POS_W-1:0] pos,
				logic [kgec_pkg::CHAR_W-1:0] base, logic [kgec_pkg::LCP_W-1:0] lcp,
				logic ends_bucket);
			logic [kgec_pkg::CNT_W-1:0] cnt;
			if (!at_bucket_start && lcp < kmer_size) begin
				close_interval();
				if (32'(lcp) + 32'd1 < 32'(kmer_size))
					close_group();
			end
			if (slot < ALPHABET) begin
				cnt = counts[slot];
				if (cnt == '0)
					first_base[slot] = base;
				if (32'(cnt) < MAX_TRUST)
					positions[slot][cnt] = pos;
				if (cnt < kgec_pkg::CNT_MAX)
					counts[slot] = cnt + 16'd1;
			end
			at_bucket_start = 1'b0;
			if (ends_bucket) begin
				close_interval();
				close_group();
				at_bucket_start = 1'b1;
			end
		endfunction

		function void check_fix(logic [kgec_pkg::POS_W-1:0] pos,
				logic [kgec_pkg::CHAR_W-1:0] base, logic tail);
			fix_t want;
			if (expected_fixes.size() == 0) begin
				$display("%0t: correction pos %h base %0d last %0b with none pending",
					$time, pos, base, tail);
				fails++;
				return;
			end
			want = expected_fixes.pop_front();
			if (pos !== want.pos) begin
				$display("%0t: corrected_pos expected %h, got %h", $time, want.pos, pos);
				fails++;
			end
			if (base !== want.base) begin
				$display("%0t: new_char expected %0d, got %0d", $time, want.base, base);
				fails++;
			end
			if (tail !== want.tail) begin
				$display("%0t: last_correction expected %0b, got %0b", $time, want.tail, tail);
				fails++;
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [kgec_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [kgec_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [kgec_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                            s_axis_tlast;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [kgec_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tlast;

	correction_board board = new();

	logic [kgec_pkg::K_W-1:0]   tb_k;
	logic [kgec_pkg::THR_W-1:0] tb_thr;
	logic [kgec_pkg::POS_W-1:0] tb_mirror;
	bit                         bucket_open = 1'b0;
	bit                         quiet = 1'b0;
	bit                         hold_armed = 1'b0;
	bit                         hold_taken = 1'b0;
	int unsigned                hold_left = 0;
	int unsigned                rx_wait = 0;
	int unsigned                items_sent = 0;
	int unsigned                cycle_count = 0;

	kmer_group_error_corrector_unit uut (
		.clk,
		.arst_n,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tlast,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tlast
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (hold_armed && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			board.check_fix(m_axis_tdata[kgec_pkg::POS_W-1:0],
				m_axis_tdata[kgec_pkg::POS_W+kgec_pkg::CHAR_W-1:kgec_pkg::POS_W],
				m_axis_tlast);
			rx_wait = quiet ? 0 : $urandom_range(9, 0);
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [kgec_pkg::LCP_W-1:0] pick_lcp(link_t link);
		int unsigned kk;
		kk = 32'(tb_k);
		case (link)
			LINK_SAME:
				if (kk == 0 || $urandom_range(2, 0) != 0)
					return (kk == 0) ? kgec_pkg::LCP_W'($urandom) :
						kgec_pkg::LCP_W'($urandom_range(65535, kk));
				else
					return kgec_pkg::LCP_W'(kk);
			LINK_SIBLING:
				return (kk == 0) ? kgec_pkg::LCP_W'($urandom) : kgec_pkg::LCP_W'(kk - 1);
			LINK_NEW_GROUP:
				if (kk == 0)
					return kgec_pkg::LCP_W'($urandom);
				else if (kk == 1)
					return '0;
				else if ($urandom_range(2, 0) == 0)
					return kgec_pkg::LCP_W'(kk - 2);
				else
					return kgec_pkg::LCP_W'($urandom_range(kk - 2, 0));
			default:
				return kgec_pkg::LCP_W'($urandom);
		endcase
	endfunction

	function automatic logic [kgec_pkg::POS_W-1:0] pick_pos();
		case ($urandom_range(3, 0))
			0: return $urandom;
			1: return tb_mirror - {16'b0, tb_k} + $urandom_range(3, 0) - 32'd1;
			2: return $urandom_range(255, 0);
			default: return 32'hFFFF_FFFF - $urandom_range(255, 0);
		endcase
	endfunction

	task automatic send_occ(logic [kgec_pkg::POS_W-1:0] pos, logic [kgec_pkg::CHAR_W-1:0] base,
			logic [kgec_pkg::LCP_W-1:0] lcp, logic ends_bucket);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(9, 0);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(kgec_pkg::IN_DATA_W - kgec_pkg::LCP_W - kgec_pkg::CHAR_W -
			kgec_pkg::POS_W){1'b0}}, lcp, base, pos};
		s_axis_tlast <= ends_bucket;
		do @(posedge clk); while (!s_axis_tready);
		board.note_occurrence(pos, base, lcp, ends_bucket);
		bucket_open = !ends_bucket;
		items_sent++;
	endtask

	// One group: interval i gets sizes[i] occurrences, most of them sharing one last base.
	task automatic send_group(int unsigned sizes[$], bit ends_bucket);
		link_t                       link;
		logic [kgec_pkg::CHAR_W-1:0] base;
		logic [kgec_pkg::CHAR_W-1:0] noise;
		for (int i = 0; i < sizes.size(); i++) begin
			base = kgec_pkg::CHAR_W'($urandom);
			for (int unsigned j = 0; j < sizes[i]; j++) begin
				if (j != 0)
					link = LINK_SAME;
				else if (i != 0)
					link = LINK_SIBLING;
				else
					link = bucket_open ? LINK_NEW_GROUP : LINK_ANY;
				noise = kgec_pkg::CHAR_W'($urandom);
				send_occ(pick_pos(), ($urandom_range(3, 0) == 0) ? noise : base, pick_lcp(link),
					ends_bucket && i == sizes.size() - 1 && j == sizes[i] - 1);
			end
		end
	endtask

	task automatic random_bucket();
		int unsigned groups;
		int unsigned intervals;
		int unsigned base_size;
		int unsigned sizes[$];
		base_size = (32'(tb_thr) > MAX_TRUST) ? MAX_TRUST : 32'(tb_thr);
		if (base_size == 0)
			base_size = 1;
		groups = $urandom_range(3, 1);
		for (int g = 0; g < groups; g++) begin
			sizes.delete();
			intervals = $urandom_range(5, 1);
			for (int i = 0; i < intervals; i++) begin
				if ($urandom_range(2, 0) == 0)
					sizes.push_back(base_size + $urandom_range(1, 0));
				else
					sizes.push_back($urandom_range(base_size, 1));
			end
			send_group(sizes, g == groups - 1);
		end
	endtask

	task automatic random_phase(int unsigned count);
		int unsigned target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(3, 0) == 0)
				send_occ(pick_pos(), kgec_pkg::CHAR_W'($urandom), kgec_pkg::LCP_W'($urandom),
					$urandom_range(5, 0) == 0);
			else
				random_bucket();
		end
	endtask

	task automatic write_reg(logic [kgec_pkg::CFG_IDX_W-1:0] index,
			logic [kgec_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(index, value);
	endtask

	task automatic configure(logic [kgec_pkg::K_W-1:0] k, logic [kgec_pkg::THR_W-1:0] thr,
			logic [kgec_pkg::POS_W-1:0] mirror, logic [kgec_pkg::POS_W-1:0] total);
		logic [31:0] filler;
		filler = $urandom;
		write_reg(kgec_pkg::REG_KMER_SIZE, {filler[15:0], k});
		write_reg(kgec_pkg::REG_TRUST_THRESHOLD, {filler[31:5], thr});
		write_reg(kgec_pkg::REG_FIRST_MIRROR_POS, mirror);
		write_reg(kgec_pkg::REG_TOTAL_LENGTH, total);
		cfg_valid <= 1'b0;
		tb_k = k;
		tb_thr = thr;
		tb_mirror = mirror;
	endtask

	// Close any open bucket, then let the block drain before the next register write.
	task automatic finish_phase();
		if (bucket_open)
			send_occ(pick_pos(), kgec_pkg::CHAR_W'($urandom), kgec_pkg::LCP_W'($urandom), 1'b1);
		s_axis_tvalid <= 1'b0;
		while (board.expected_fixes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned plan[$];
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_UNUSED, $urandom);
		configure(16'd5, 5'd3, 32'd1000, 32'd2000);
		// Trusted interval, one folded and one wrapped correction.
		send_occ(32'hFFFF_FFFF, 2'd1, 16'hFFFF, 1'b0);
		send_occ(32'd100, 2'd1, 16'd5, 1'b0);
		send_occ(32'd200, 2'd1, 16'hFFFF, 1'b0);
		send_occ(32'd996, 2'd2, 16'd4, 1'b0);
		send_occ(32'd994, 2'd3, 16'd4, 1'b0);
		send_occ(32'hFFFF_FFFE, 2'd3, 16'd9, 1'b0);
		// Two intervals tie at the threshold; the earlier one wins.
		send_occ(32'd10, 2'd0, 16'd0, 1'b0);
		send_occ(32'd11, 2'd0, 16'd5, 1'b0);
		send_occ(32'd0, 2'd0, 16'd6, 1'b0);
		send_occ(32'd12, 2'd2, 16'd4, 1'b0);
		send_occ(32'd13, 2'd2, 16'd7, 1'b0);
		send_occ(32'd14, 2'd2, 16'd5, 1'b0);
		send_occ(32'd1500, 2'd3, 16'd4, 1'b0);
		// Five intervals in one group; the fifth is dropped.
		send_occ(32'd20, 2'd0, 16'd3, 1'b0);
		send_occ(32'd21, 2'd1, 16'd4, 1'b0);
		send_occ(32'd22, 2'd1, 16'd5, 1'b0);
		send_occ(32'd23, 2'd1, 16'd5, 1'b0);
		send_occ(32'd24, 2'd2, 16'd4, 1'b0);
		send_occ(32'd25, 2'd3, 16'd4, 1'b0);
		send_occ(32'd26, 2'd0, 16'd4, 1'b0);
		// Nothing trusted at the bucket end, then a one-word bucket.
		send_occ(32'd30, 2'd2, 16'd1, 1'b0);
		send_occ(32'd31, 2'd3, 16'd4, 1'b1);
		send_occ(32'd40, 2'd1, 16'd2, 1'b1);
		finish_phase();

		configure(16'd31, 5'd3, 32'h8000_0000, 32'hFFFF_FFFF);
		random_phase(45);
		finish_phase();

		configure(16'hFFFF, 5'd16, 32'hFFFF_FFFF, 32'h0);
		plan = {};
		plan.push_back(16);
		plan.push_back(15);
		plan.push_back(15);
		plan.push_back(15);
		send_group(plan, 1'b1);
		random_phase(10);
		finish_phase();

		quiet = 1'b1;
		configure(16'd1, 5'd1, 32'h0, 32'hFFFF_FFFF);
		random_phase(40);
		finish_phase();
		quiet = 1'b0;

		configure(16'd0, 5'd2, 32'h4000_0000, 32'h7FFF_FFFF);
		random_phase(40);
		finish_phase();

		configure(16'd4, 5'd31, $urandom, $urandom);
		random_phase(10);
		finish_phase();

		configure(16'd3, 5'd0, 32'h100, 32'h200);
		random_phase(25);
		finish_phase();

		// The receiver stops for a long stretch while whole groups keep arriving.
		configure(16'd7, 5'd4, 32'h8000_0000, 32'hFFFF_FFFF);
		hold_armed = 1'b1;
		plan = {};
		plan.push_back(4);
		plan.push_back(3);
		plan.push_back(3);
		plan.push_back(3);
		repeat (4) send_group(plan, 1'b0);
		finish_phase();

		if (board.fails == 0 && board.expected_fixes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
